// ----- hdl/aqi_pkg.sv -----
// Shared types, breakpoint tables and constants for the particle-reading AQI block.
// Used by aqi_lane, air_quality_index_from_pm_unit and aqi_chk; depends on nothing.
`default_nettype none

package aqi_pkg;

    localparam int unsigned NUM_BREAKPOINTS = 8;
    localparam int unsigned TABLE_LEN       = 8;
    localparam int unsigned NB_USED = (NUM_BREAKPOINTS > TABLE_LEN) ? TABLE_LEN : NUM_BREAKPOINTS;
    localparam int unsigned NUM_SEG = NB_USED - 1;

    localparam int unsigned BP_W   = $clog2(TABLE_LEN);
    localparam int unsigned CONC_W = 16;
    localparam int unsigned IDX_W  = 9;
    localparam int unsigned OFF_W  = 8;   // widest segment span is 150
    localparam int unsigned DL2_W  = 8;   // twice the widest level step (200)
    localparam int unsigned X_W    = 15;  // 2*dl*off + span stays below 2^15
    localparam int unsigned RCP_SH = 24;
    localparam int unsigned RCP_W  = 19;
    localparam int unsigned PROD_W = X_W + RCP_W;
    localparam int unsigned Q_W    = 7;   // quotient never exceeds one level step

    // register stages in one lane, and in the whole path from an accepted beat to its result strobe
    localparam int unsigned LANE_LAT  = 5;
    localparam int unsigned PIPE_LAT  = LANE_LAT + 1;

    localparam logic [IDX_W-1:0] INDEX_MAX = 9'd500;

    typedef logic [CONC_W-1:0] conc_t;
    typedef logic [IDX_W-1:0]  index_t;
    typedef logic [BP_W-1:0]   bp_idx_t;

    typedef struct packed {
        conc_t pm25_conc;
        conc_t pm10_conc;
    } aqi_in_t;

    typedef struct packed {
        index_t pm25_index;
        index_t pm10_index;
        index_t overall_index;
    } aqi_out_t;

    typedef enum logic {
        POLL_PM25 = 1'b0,
        POLL_PM10 = 1'b1
    } poll_t;

    localparam conc_t PM25_CONC [TABLE_LEN] = '{
        16'd0, 16'd25, 16'd50, 16'd80, 16'd150, 16'd250, 16'd350, 16'd500
    };
    localparam conc_t PM10_CONC [TABLE_LEN] = '{
        16'd0, 16'd50, 16'd150, 16'd250, 16'd350, 16'd420, 16'd520, 16'd600
    };
    localparam index_t BP_LEVEL [TABLE_LEN] = '{
        9'd0, 9'd50, 9'd100, 9'd150, 9'd200, 9'd300, 9'd400, 9'd500
    };

    // ceil(2^24 / (2*span)) per segment; exact floor for every dividend below 2^15
    localparam longint unsigned RCP_ONE = 64'd1 << RCP_SH;
    localparam logic [RCP_W-1:0] PM25_RCP [TABLE_LEN-1] = '{
        RCP_W'((RCP_ONE + 50 - 1) / 50),
        RCP_W'((RCP_ONE + 50 - 1) / 50),
        RCP_W'((RCP_ONE + 60 - 1) / 60),
        RCP_W'((RCP_ONE + 140 - 1) / 140),
        RCP_W'((RCP_ONE + 200 - 1) / 200),
        RCP_W'((RCP_ONE + 200 - 1) / 200),
        RCP_W'((RCP_ONE + 300 - 1) / 300)
    };
    localparam logic [RCP_W-1:0] PM10_RCP [TABLE_LEN-1] = '{
        RCP_W'((RCP_ONE + 100 - 1) / 100),
        RCP_W'((RCP_ONE + 200 - 1) / 200),
        RCP_W'((RCP_ONE + 200 - 1) / 200),
        RCP_W'((RCP_ONE + 200 - 1) / 200),
        RCP_W'((RCP_ONE + 140 - 1) / 140),
        RCP_W'((RCP_ONE + 200 - 1) / 200),
        RCP_W'((RCP_ONE + 160 - 1) / 160)
    };

    function automatic conc_t bp_conc(poll_t p, bp_idx_t i);
        conc_t c;
        unique case (p)
            POLL_PM25: c = PM25_CONC[i];
            POLL_PM10: c = PM10_CONC[i];
            default:   c = PM25_CONC[i];
        endcase
        return c;
    endfunction

    function automatic logic [OFF_W-1:0] seg_span(poll_t p, bp_idx_t s);
        conc_t d;
        d = bp_conc(p, s + BP_W'(1)) - bp_conc(p, s);
        return d[OFF_W-1:0];
    endfunction

    function automatic logic [DL2_W-1:0] seg_dl2(bp_idx_t s);
        index_t d;
        d = BP_LEVEL[s + BP_W'(1)] - BP_LEVEL[s];
        return {d[DL2_W-2:0], 1'b0};
    endfunction

    function automatic logic [RCP_W-1:0] seg_rcp(poll_t p, bp_idx_t s);
        logic [RCP_W-1:0] r;
        unique case (p)
            POLL_PM25: r = PM25_RCP[s];
            POLL_PM10: r = PM10_RCP[s];
            default:   r = PM25_RCP[s];
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/air_quality_index_from_pm_unit.sv -----
// Air quality index from a PM2.5/PM10 reading pair: two sub-index lanes and a max stage.
// Depends on aqi_pkg and aqi_lane.
// done is registered and comes in the same cycle as that beat's result on rsp.
// Throughput is set by the fully pipelined lanes: one beat per cycle; busy is never asserted.
// Reset clears the valid pipeline; payload registers are not reset.
`default_nettype none

module air_quality_index_from_pm_unit (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire aqi_pkg::aqi_in_t req,
    output logic                  done,
    output aqi_pkg::aqi_out_t     rsp
);

    aqi_pkg::index_t pm25_idx;
    aqi_pkg::index_t pm10_idx;

    logic [aqi_pkg::LANE_LAT-1:0] vld_reg;
    logic [aqi_pkg::LANE_LAT-1:0] vld_next;
    logic                         done_reg;
    aqi_pkg::aqi_out_t            rsp_reg;
    aqi_pkg::aqi_out_t            rsp_next;

    assign busy = 1'b0;

    aqi_lane u_pm25 (
        .clk   (clk),
        .poll  (aqi_pkg::POLL_PM25),
        .conc  (req.pm25_conc),
        .index (pm25_idx)
    );

    aqi_lane u_pm10 (
        .clk   (clk),
        .poll  (aqi_pkg::POLL_PM10),
        .conc  (req.pm10_conc),
        .index (pm10_idx)
    );

    assign vld_next = {vld_reg[aqi_pkg::LANE_LAT-2:0], start & ~busy};

    always_comb
    begin
        rsp_next.pm25_index    = pm25_idx;
        rsp_next.pm10_index    = pm10_idx;
        rsp_next.overall_index = (pm25_idx > pm10_idx) ? pm25_idx : pm10_idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= vld_next;
            done_reg <= vld_reg[aqi_pkg::LANE_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

// ----- hdl/aqi_lane.sv -----
// One sub-index lane: segment search, offset, numerator, reciprocal multiply, level add.
// Five register stages; depends on aqi_pkg for tables and widths.
`default_nettype none

module aqi_lane (
    input  wire logic           clk,
    input  wire aqi_pkg::poll_t poll,
    input  wire aqi_pkg::conc_t conc,
    output aqi_pkg::index_t     index
);

    // stage 1: segment search
    logic                 hit;
    aqi_pkg::bp_idx_t     seg;
    aqi_pkg::conc_t       s1_conc_reg;
    aqi_pkg::bp_idx_t     s1_seg_reg;
    logic                 s1_sat_reg;

    // stage 2: offset into the segment
    logic [aqi_pkg::OFF_W-1:0] off_next;
    aqi_pkg::conc_t            off_full;
    logic [aqi_pkg::OFF_W-1:0] s2_off_reg;
    aqi_pkg::bp_idx_t          s2_seg_reg;
    logic                      s2_sat_reg;

    // stage 3: rounded numerator
    logic [aqi_pkg::OFF_W+aqi_pkg::DL2_W:0] x_full;
    logic [aqi_pkg::X_W-1:0]   s3_x_reg;
    aqi_pkg::bp_idx_t          s3_seg_reg;
    logic                      s3_sat_reg;

    // stage 4: multiply by reciprocal of twice the span
    logic [aqi_pkg::PROD_W-1:0] s4_prod_reg;
    aqi_pkg::bp_idx_t           s4_seg_reg;
    logic                       s4_sat_reg;

    // stage 5: level add and saturation
    aqi_pkg::index_t index_next;
    aqi_pkg::index_t s5_index_reg;

    // tables are increasing, so the first segment whose top covers the reading wins
    always_comb
    begin
        hit = 1'b0;
        seg = '0;
        for (int i = int'(aqi_pkg::NUM_SEG) - 1; i >= 0; i--)
        begin
            if (conc <= aqi_pkg::bp_conc(poll, aqi_pkg::BP_W'(i + 1)))
            begin
                hit = 1'b1;
                seg = aqi_pkg::BP_W'(i);
            end
        end
    end

    assign off_full = s1_conc_reg - aqi_pkg::bp_conc(poll, s1_seg_reg);
    assign off_next = off_full[aqi_pkg::OFF_W-1:0];

    assign x_full = (aqi_pkg::OFF_W + aqi_pkg::DL2_W + 1)'(aqi_pkg::seg_dl2(s2_seg_reg) * s2_off_reg)
                  + (aqi_pkg::OFF_W + aqi_pkg::DL2_W + 1)'(aqi_pkg::seg_span(poll, s2_seg_reg));

    always_comb
    begin
        if (s4_sat_reg)
            index_next = aqi_pkg::INDEX_MAX;
        else
            index_next = aqi_pkg::BP_LEVEL[s4_seg_reg]
                       + aqi_pkg::IDX_W'(s4_prod_reg[aqi_pkg::RCP_SH +: aqi_pkg::Q_W]);
    end

    always_ff @(posedge clk)
    begin
        s1_conc_reg  <= conc;
        s1_seg_reg   <= seg;
        s1_sat_reg   <= ~hit;

        s2_off_reg   <= off_next;
        s2_seg_reg   <= s1_seg_reg;
        s2_sat_reg   <= s1_sat_reg;

        s3_x_reg     <= x_full[aqi_pkg::X_W-1:0];
        s3_seg_reg   <= s2_seg_reg;
        s3_sat_reg   <= s2_sat_reg;

        s4_prod_reg  <= aqi_pkg::PROD_W'(s3_x_reg * aqi_pkg::seg_rcp(poll, s3_seg_reg));
        s4_seg_reg   <= s3_seg_reg;
        s4_sat_reg   <= s3_sat_reg;

        s5_index_reg <= index_next;
    end

    assign index = s5_index_reg;

endmodule

`default_nettype wire

// ----- hdl/aqi_chk.sv -----
// Port-level checker for air_quality_index_from_pm_unit, bound to the top level.
// Depends on aqi_pkg for the result type and the latency constant.
`default_nettype none

module aqi_chk (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire aqi_pkg::aqi_in_t  req,
    input wire logic              done,
    input wire aqi_pkg::aqi_out_t rsp
);

    // the pipeline never pushes back
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy == 1'b0)
        else $error("busy asserted");

    // every accepted beat yields a strobe after the fixed latency
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(aqi_pkg::PIPE_LAT) done)
        else $error("missing result strobe");

    // no strobe without an accepted beat
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, aqi_pkg::PIPE_LAT))
        else $error("result strobe without a beat");

    a_overall_max: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.overall_index == ((rsp.pm25_index > rsp.pm10_index) ?
                                        rsp.pm25_index : rsp.pm10_index))
              && (rsp.pm25_index <= aqi_pkg::INDEX_MAX)
              && (rsp.pm10_index <= aqi_pkg::INDEX_MAX))
        else $error("overall index is not the max of the sub-indices");

    a_zero_reading: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.pm25_conc == '0 && req.pm10_conc == '0)
            |-> ##(aqi_pkg::PIPE_LAT) (rsp.overall_index == '0))
        else $error("zero reading gave a nonzero index");

endmodule

bind air_quality_index_from_pm_unit aqi_chk u_aqi_chk (.*);

`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for air_quality_index_from_pm_unit: directed table, then random beats.
// Predicts both sub-indices and the overall index, and checks every result beat in order.
// Depends on aqi_pkg (port types, breakpoint count, pipeline latency) and the unit itself.
`default_nettype none

module tb;

    localparam int unsigned SAT_INDEX = 500;
    localparam int unsigned SEG_USED  =
        ((aqi_pkg::NUM_BREAKPOINTS > 8) ? 8 : aqi_pkg::NUM_BREAKPOINTS) - 1;
    localparam int unsigned RAND_BEATS = 850;
    localparam int unsigned DIR_ROWS   = 22;

    localparam int unsigned pm25_bp_conc [8] = '{0, 25, 50, 80, 150, 250, 350, 500};
    localparam int unsigned pm10_bp_conc [8] = '{0, 50, 150, 250, 350, 420, 520, 600};
    localparam int unsigned bp_index     [8] = '{0, 50, 100, 150, 200, 300, 400, 500};

    typedef struct {
        aqi_pkg::aqi_in_t  beat;
        bit                fixed;
        aqi_pkg::aqi_out_t want;
    } dir_row_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    aqi_pkg::aqi_in_t  req;
    logic              done;
    aqi_pkg::aqi_out_t rsp;

    aqi_pkg::aqi_out_t pending_aqi [$];
    int                err_count;

    air_quality_index_from_pm_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // piecewise-linear sub-index, first enclosing segment wins, rounded half up
    function automatic aqi_pkg::index_t pm_to_index(input aqi_pkg::conc_t conc,
                                                    input bit is_pm10);
        int unsigned c;
        int unsigned lo;
        int unsigned hi;
        int unsigned il;
        int unsigned ih;
        int unsigned span;
        int unsigned result;
        bit          found;
        c = conc;
        result = SAT_INDEX;
        found = 1'b0;
        for (int s = 0; s < SEG_USED; s++)
        begin
            lo = is_pm10 ? pm10_bp_conc[s] : pm25_bp_conc[s];
            hi = is_pm10 ? pm10_bp_conc[s+1] : pm25_bp_conc[s+1];
            if (!found && c >= lo && c <= hi)
            begin
                found = 1'b1;
                il = bp_index[s];
                ih = bp_index[s+1];
                span = hi - lo;
                if (span == 0 || ih < il)
                    result = il;
                else
                    result = il + (2 * (ih - il) * (c - lo) + span) / (2 * span);
            end
        end
        return aqi_pkg::index_t'(result);
    endfunction

    function automatic aqi_pkg::aqi_out_t predict_aqi(input aqi_pkg::aqi_in_t beat);
        aqi_pkg::aqi_out_t r;
        r.pm25_index = pm_to_index(beat.pm25_conc, 1'b0);
        r.pm10_index = pm_to_index(beat.pm10_conc, 1'b1);
        r.overall_index = (r.pm25_index > r.pm10_index) ? r.pm25_index : r.pm10_index;
        return r;
    endfunction

    // mostly in-table readings, some near breakpoints, some anywhere in 16 bits
    function automatic aqi_pkg::conc_t pick_conc(input bit is_pm10);
        int unsigned    sel;
        int unsigned    bp;
        aqi_pkg::conc_t c;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            c = aqi_pkg::conc_t'($urandom_range(0, is_pm10 ? 620 : 520));
        else if (sel < 8)
        begin
            bp = is_pm10 ? pm10_bp_conc[$urandom_range(0, 7)] : pm25_bp_conc[$urandom_range(0, 7)];
            c = aqi_pkg::conc_t'(bp + $urandom_range(0, 2) - 1);
        end
        else if (sel == 8)
            c = aqi_pkg::conc_t'($urandom_range(0, 2047));
        else
            c = aqi_pkg::conc_t'($urandom);
        return c;
    endfunction

    task automatic send_reading(input aqi_pkg::aqi_in_t beat, input aqi_pkg::aqi_out_t want);
        start <= 1'b1;
        req <= beat;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        pending_aqi.push_back(want);
    endtask

    task automatic idle_for(input int unsigned cycles);
        if (cycles != 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_aqi.size() != 0)
            @(posedge clk);
    endtask

    // result checker: the receiver cannot stall, so every strobe is a beat
    always @(posedge clk)
    begin
        aqi_pkg::aqi_out_t want;
        if (rst_n === 1'b1 && done !== 1'b0)
        begin
            if (done !== 1'b1)
            begin
                $display("%0t: done is unknown", $time);
                err_count++;
            end
            else if (pending_aqi.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, got %p", $time, rsp);
                err_count++;
            end
            else
            begin
                want = pending_aqi.pop_front();
                if (rsp.pm25_index !== want.pm25_index)
                begin
                    $display("%0t: pm25_index expected %0d got %0d",
                             $time, want.pm25_index, rsp.pm25_index);
                    err_count++;
                end
                if (rsp.pm10_index !== want.pm10_index)
                begin
                    $display("%0t: pm10_index expected %0d got %0d",
                             $time, want.pm10_index, rsp.pm10_index);
                    err_count++;
                end
                if (rsp.overall_index !== want.overall_index)
                begin
                    $display("%0t: overall_index expected %0d got %0d",
                             $time, want.overall_index, rsp.overall_index);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        dir_row_t          dir_rows [DIR_ROWS];
        aqi_pkg::aqi_in_t  beat;
        aqi_pkg::aqi_out_t want;
        int unsigned       sent;
        int unsigned       burst;
        int unsigned       waited;

        err_count = 0;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;

        dir_rows = '{
            '{{16'd0, 16'd0}, 1'b1, {9'd0, 9'd0, 9'd0}},
            '{{16'd65535, 16'd65535}, 1'b1, {9'd500, 9'd500, 9'd500}},
            '{{16'd25, 16'd50}, 1'b1, {9'd50, 9'd50, 9'd50}},
            '{{16'd50, 16'd150}, 1'b1, {9'd100, 9'd100, 9'd100}},
            '{{16'd80, 16'd250}, 1'b1, {9'd150, 9'd150, 9'd150}},
            '{{16'd150, 16'd350}, 1'b1, {9'd200, 9'd200, 9'd200}},
            '{{16'd250, 16'd420}, 1'b1, {9'd300, 9'd300, 9'd300}},
            '{{16'd350, 16'd520}, 1'b1, {9'd400, 9'd400, 9'd400}},
            '{{16'd500, 16'd600}, 1'b1, {9'd500, 9'd500, 9'd500}},
            '{{16'd501, 16'd601}, 1'b1, {9'd500, 9'd500, 9'd500}},
            '{{16'd0, 16'd65535}, 1'b1, {9'd0, 9'd500, 9'd500}},
            '{{16'd65535, 16'd0}, 1'b1, {9'd500, 9'd0, 9'd500}},
            '{{16'd0, 16'd51}, 1'b0, '0},        // exact half, rounds up
            '{{16'd12, 16'd522}, 1'b0, '0},      // x.5 in the top PM10 segment
            '{{16'd51, 16'd0}, 1'b0, '0},
            '{{16'd1, 16'd1}, 1'b0, '0},
            '{{16'd499, 16'd599}, 1'b0, '0},
            '{{16'd26, 16'd49}, 1'b0, '0},
            '{{16'h8000, 16'h8000}, 1'b1, {9'd500, 9'd500, 9'd500}},
            '{{16'h5555, 16'haaaa}, 1'b1, {9'd500, 9'd500, 9'd500}},
            '{{16'd100, 16'd300}, 1'b0, '0},
            '{{16'd200, 16'd400}, 1'b0, '0}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            want = dir_rows[i].fixed ? dir_rows[i].want : predict_aqi(dir_rows[i].beat);
            send_reading(dir_rows[i].beat, want);
            idle_for($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0);
        end
        drain_results();

        sent = 0;
        while (sent < RAND_BEATS)
        begin
            // one long back-to-back stretch now and then
            burst = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 16);
            for (int b = 0; b < burst && sent < RAND_BEATS; b++)
            begin
                beat.pm25_conc = pick_conc(1'b0);
                beat.pm10_conc = pick_conc(1'b1);
                send_reading(beat, predict_aqi(beat));
                sent++;
                if (sent == RAND_BEATS / 2)
                    drain_results();
            end
            idle_for($urandom_range(0, 5));
        end

        start <= 1'b0;
        waited = 0;
        while (pending_aqi.size() != 0 && waited < 1000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (aqi_pkg::PIPE_LAT + 4) @(posedge clk);

        if (err_count == 0 && pending_aqi.size() == 0)
            $display("Simulation PASSED");
        else
        begin
            if (pending_aqi.size() != 0)
                $display("%0t: %0d expected results never arrived", $time, pending_aqi.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("%0t: run timed out", $time);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- air_quality_index_from_pm_unit.f -----
hdl/aqi_pkg.sv
hdl/aqi_lane.sv
hdl/air_quality_index_from_pm_unit.sv
hdl/aqi_chk.sv
verif/tb.sv
